// ===== hw/rtl/square_region_rotator_top_defines.svh =====
// Assertion macros used by the square region rotator top.
// No dependencies; the clock i_clk and reset i_rst_n must be in scope.
`ifndef SQUARE_REGION_ROTATOR_TOP_DEFINES_SVH
`define SQUARE_REGION_ROTATOR_TOP_DEFINES_SVH

// Same-cycle implication, muted while reset is asserted
`define SRR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is asserted
`define SRR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/srr_pkg.sv =====
// Shared types and constants for the square region rotator.
// No dependencies; imported by every module of the block.
package srr_pkg;

    localparam int CELL_W  = 13;
    localparam int COORD_W = 7;
    localparam int RAD_W   = 5;
    localparam int SIDE_W  = 7;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

    // request type codes
    localparam logic [1:0] REQ_INIT   = 2'd0;
    localparam logic [1:0] REQ_ROTATE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic [RAD_W-1:0]   radius;
        logic               direction;
    } t_req;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic              status;
    } t_rsp;

    // control from the main sequencer to the ring walker
    typedef struct packed {
        logic load;
        logic step;
    } t_seq_ctl;

    // the four cells of one rotation group, entry 0 first in the swap chain
    typedef struct packed {
        logic [3:0][COORD_W-1:0] row;
        logic [3:0][COORD_W-1:0] col;
        logic                    last;
    } t_ring_cells;

endpackage

// ===== hw/rtl/srr_grid_mem.sv =====
// Grid cell store: one write port and one read port, registered read data.
// Depends on srr_pkg for the cell width.
module srr_grid_mem import srr_pkg::*; #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [CELL_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [CELL_W-1:0]        o_rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/srr_ring_seq.sv =====
// Ring walker: steps through the rings and positions of a rotation and
// gives the four cells of each swap group. Depends on srr_pkg.
module srr_ring_seq import srr_pkg::*; (
    input  logic        i_clk,
    input  t_seq_ctl    i_ctl,
    input  t_req        i_req,
    output t_ring_cells o_cells
);

    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [RAD_W-1:0]   r_r;
    logic               r_ccw;
    logic [RAD_W-1:0]   r_j;
    logic [RAD_W:0]     r_k;

    logic [RAD_W:0]     k_end;
    logic [COORD_W-1:0] top, bot, lft, rgt, kk;

    // ring j runs positions k = 0 .. 2j-1
    assign k_end = {r_j, 1'b0} - (RAD_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x   <= i_req.center_row;
            r_y   <= i_req.center_col;
            r_r   <= i_req.radius;
            r_ccw <= i_req.direction;
            r_j   <= RAD_W'(1);
            r_k   <= '0;
        end else if (i_ctl.step) begin
            if (r_k == k_end) begin
                r_j <= r_j + RAD_W'(1);
                r_k <= '0;
            end else begin
                r_k <= r_k + (RAD_W+1)'(1);
            end
        end
    end

    // ring bounds for the current group
    always_comb begin
        top = COORD_W'(r_x - COORD_W'(r_j));
        bot = COORD_W'(r_x + COORD_W'(r_j));
        lft = COORD_W'(r_y - COORD_W'(r_j));
        rgt = COORD_W'(r_y + COORD_W'(r_j));
        kk  = COORD_W'(r_k);
    end

    // cells of the group; each takes the value of the next one in the chain
    always_comb begin
        o_cells.last = (r_k == k_end) && (r_j == r_r);
        if (r_ccw) begin
            o_cells.row[0] = COORD_W'(top + kk);  o_cells.col[0] = lft;
            o_cells.row[1] = top;                 o_cells.col[1] = COORD_W'(rgt - kk);
            o_cells.row[2] = COORD_W'(bot - kk);  o_cells.col[2] = rgt;
            o_cells.row[3] = bot;                 o_cells.col[3] = COORD_W'(lft + kk);
        end else begin
            o_cells.row[0] = top;                 o_cells.col[0] = COORD_W'(lft + kk);
            o_cells.row[1] = COORD_W'(bot - kk);  o_cells.col[1] = lft;
            o_cells.row[2] = bot;                 o_cells.col[2] = COORD_W'(rgt - kk);
            o_cells.row[3] = COORD_W'(top + kk);  o_cells.col[3] = rgt;
        end
    end

endmodule

// ===== hw/rtl/square_region_rotator_top.sv =====
// Square region rotator: grid store in one memory with init, rotate and read.
// Depends on srr_pkg, srr_grid_mem, srr_ring_seq and the assertion header.
//
// Usage:
//   A request is taken on a rising edge with start high and busy low. Every
//   request gives exactly one result on o_result, shown for one cycle with
//   o_result_valid high; the receiver cannot hold it off.
//   The side register is written through i_cfg_valid / o_cfg_ready (always
//   ready). Write it only while the block is idle; the block does not enforce it.
// Steps per request type, from the accepting edge to the result:
//   rejected rotate or read, unknown type, init of an empty grid: direct from idle.
//   read: address state, memory read state, then the result.
//   init: all n*n cells, one cell written per cycle (n = side in use).
//   rotate of radius r: rings 1 to r, or no cell at all when r is 0.
//   Each group of four cells is read while the previous group is written
//   back, so the single read and single write port of the grid memory
//   set the rate at about one cell per cycle.
// Reset: a clearing pass writes zero to all MAX_SIDE*MAX_SIDE cells, one
//   per cycle; busy stays high until the pass ends. Side resets to 64.
`include "square_region_rotator_top_defines.svh"

module square_region_rotator_top import srr_pkg::*; #(
    parameter int MAX_SIDE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIDE_W-1:0] i_cfg_data,
    output logic              o_result_valid,
    output t_rsp              o_result
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    // sequencer states
    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_INIT    = 3'd2;
    localparam logic [2:0] ST_ROT     = 3'd3;
    localparam logic [2:0] ST_RD_ADDR = 3'd4;
    localparam logic [2:0] ST_RD_DATA = 3'd5;

    // zero-based row and column to memory address
    function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] row0,
                                                input logic [COORD_W-1:0] col0);
        return AW'(int'(row0) * MAX_SIDE + int'(col0));
    endfunction

    // control registers
    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [1:0]        r_q, n_q;
    logic              r_rv, n_rv;
    logic              r_cap, n_cap;
    logic              r_wv, n_wv;
    logic              r_out_valid, n_out_valid;
    logic [SIDE_W-1:0] r_side;

    // payload registers
    t_req                    r_req;
    logic [SIDE_W-1:0]       r_n, n_n;
    logic [COORD_W-1:0]      r_ii, n_ii;
    logic [COORD_W-1:0]      r_ij, n_ij;
    logic [CELL_W-1:0]       r_ival, n_ival;
    logic [2:0][CELL_W-1:0]  r_v;
    logic [3:0][CELL_W-1:0]  r_w;
    logic [3:0][AW-1:0]      r_ra;
    logic [3:0][AW-1:0]      r_wa;
    t_rsp                    r_out, n_out;

    logic              accept;
    logic [SIDE_W-1:0] live_n;
    logic [7:0]        x8, y8, r8, n8;
    logic              rot_bad, rd_bad;
    t_seq_ctl          seq_ctl;
    t_ring_cells       cells;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // side in use is capped at the memory size
    assign live_n = (int'(r_side) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : r_side;

    // range checks on the incoming request
    always_comb begin
        x8      = {1'b0, i_req.center_row};
        y8      = {1'b0, i_req.center_col};
        r8      = {3'b0, i_req.radius};
        n8      = {1'b0, live_n};
        rot_bad = (x8 < r8 + 8'd1) || (x8 + r8 > n8) ||
                  (y8 < r8 + 8'd1) || (y8 + r8 > n8);
        rd_bad  = (x8 == 8'd0) || (x8 > n8) || (y8 == 8'd0) || (y8 > n8);
    end

    // ring walker control
    always_comb begin
        seq_ctl.load = accept;
        seq_ctl.step = (r_state == ST_ROT) && (r_q == 2'd3) && r_rv && !cells.last;
    end

    srr_ring_seq u_ring_seq (
        .i_clk   (i_clk),
        .i_ctl   (seq_ctl),
        .i_req   (i_req),
        .o_cells (cells)
    );

    // memory write port: clearing pass, init fill, rotate write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(r_ii, r_ij);
                mem_wdata = r_ival;
            end
            ST_ROT: begin
                // write cell q-1 of the previous group with the value of cell q
                mem_we    = r_wv;
                mem_waddr = r_wa[2'(r_q - 2'd1)];
                mem_wdata = r_w[r_q];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // memory read port: cell q of the current group, or the cell to read
    always_comb begin
        if (r_state == ST_ROT) begin
            mem_raddr = cell_addr(COORD_W'(cells.row[r_q] - COORD_W'(1)),
                                  COORD_W'(cells.col[r_q] - COORD_W'(1)));
        end else begin
            mem_raddr = cell_addr(COORD_W'(r_req.center_row - COORD_W'(1)),
                                  COORD_W'(r_req.center_col - COORD_W'(1)));
        end
    end

    srr_grid_mem #(
        .DEPTH (DEPTH)
    ) u_grid_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_q         = r_q;
        n_rv        = r_rv;
        n_cap       = r_cap;
        n_wv        = r_wv;
        n_out_valid = 1'b0;
        n_out       = '0;
        n_n         = r_n;
        n_ii        = r_ii;
        n_ij        = r_ij;
        n_ival      = r_ival;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_req.req_type)
                        REQ_INIT: begin
                            if (live_n == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                n_state = ST_INIT;
                                n_n     = live_n;
                                n_ii    = '0;
                                n_ij    = '0;
                                n_ival  = CELL_W'(1);
                            end
                        end
                        REQ_ROTATE: begin
                            if (rot_bad) begin
                                n_out_valid  = 1'b1;
                                n_out.status = 1'b1;
                            end else begin
                                n_state = ST_ROT;
                                n_q     = 2'd0;
                                n_rv    = (i_req.radius != '0);
                                n_cap   = 1'b0;
                                n_wv    = 1'b0;
                            end
                        end
                        REQ_READ: begin
                            if (rd_bad) begin
                                n_out_valid  = 1'b1;
                                n_out.status = 1'b1;
                            end else begin
                                n_state = ST_RD_ADDR;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                // row-major fill, value counts up from one
                n_ival = r_ival + CELL_W'(1);
                if (r_ij == r_n - SIDE_W'(1)) begin
                    n_ij = '0;
                    if (r_ii == r_n - SIDE_W'(1)) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                    end else begin
                        n_ii = r_ii + COORD_W'(1);
                    end
                end else begin
                    n_ij = r_ij + COORD_W'(1);
                end
            end
            ST_ROT: begin
                n_q = r_q + 2'd1;
                // end of a read period: note whether a group was read
                if (r_q == 2'd3) begin
                    n_cap = r_rv;
                    if (r_rv && cells.last) begin
                        n_rv = 1'b0;
                    end
                end
                // start of a period: the group just read moves to write-back
                if (r_q == 2'd0) begin
                    n_wv = r_cap;
                    if (!r_rv && !r_cap) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_RD_ADDR: begin
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                n_state          = ST_IDLE;
                n_out_valid      = 1'b1;
                n_out.cell_value = mem_rdata;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_q         <= '0;
            r_rv        <= 1'b0;
            r_cap       <= 1'b0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_side      <= SIDE_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_q         <= n_q;
            r_rv        <= n_rv;
            r_cap       <= n_cap;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_side <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_ii   <= n_ii;
        r_ij   <= n_ij;
        r_ival <= n_ival;
        r_out  <= n_out;
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == ST_ROT) begin
            r_ra[r_q] <= mem_raddr;
            if (r_q != 2'd0) begin
                r_v[2'(r_q - 2'd1)] <= mem_rdata;
            end else begin
                // last cell of the group arrives now; hand the group to write-back
                r_w  <= {mem_rdata, r_v};
                r_wa <= r_ra;
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // checks
    `SRR_ASSERT_IMP(a_we_only_busy, mem_we, busy, "grid written while idle")
    `SRR_ASSERT_IMP(a_rot_no_overlap, (r_state == ST_ROT) && r_wv && r_rv,
                    mem_waddr != mem_raddr, "rotate read and write hit one cell")
    `SRR_ASSERT_NXT(a_accept_progress, accept, busy || o_result_valid,
                    "accepted request neither started nor answered")
    `SRR_ASSERT_IMP(a_reject_zero, o_result_valid && o_result.status,
                    o_result.cell_value == '0, "rejected request carries a value")

endmodule
